FILE: src/mcbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mcbb_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VW = $clog2(MAX_VERTICES);       // vertex index width
   localparam int CW = VW + 1;                      // count / color width
   localparam int BUDGET_W = 37;
   localparam int STEPS_W = BUDGET_W + 1;           // signed step counter
   localparam int ENTRY_W = CW + VW;                // color and vertex
   localparam int COS_AW = 2 * VW;
   localparam logic [CW-1:0] VC_RESET = CW'(MAX_VERTICES);
   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 37'd40000000000;
   localparam logic [STEPS_W-1:0] STEPS_MIN = {1'b1, {BUDGET_W{1'b0}}};

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_SOLVE = 2'd2;

   localparam logic REG_VERTEX_COUNT = 1'b0;
   localparam logic REG_STEP_BUDGET  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EDGE_WA, ST_EDGE_WB, ST_INIT, ST_ENTER, ST_CLASS, ST_PICK,
      ST_ADJ, ST_BRANCH, ST_BR_E, ST_BR_ADJ, ST_POP2, ST_POP3, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLEAR, OP_EDGE_A, OP_EDGE_WA, OP_EDGE_WB, OP_INIT, OP_ENTER,
      OP_CLASS, OP_CLASS_END, OP_PICK, OP_NEXT_COL, OP_ADJ_MASK, OP_BR_ISSUE,
      OP_PRUNE, OP_BR_TAKE, OP_LEAF, OP_DESCEND, OP_POP1, OP_POP2, OP_POP3,
      OP_FIN_EXH, OP_LOAD_RSP
   } op_type;

   typedef struct packed {
      logic self_loop;
      logic p_zero;
      logic q_zero;
      logic steps_out;
      logic i_neg;
      logic d_zero;
      logic prune;
      logic leaf;
   } status_type;

endpackage
`default_nettype wire

FILE: src/mcbb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mcbb_ctrl
   import mcbb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [1:0] req_cmd,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output op_type          op,
   output logic            req_ready,
   output logic            rsp_valid
);

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op = OP_NONE;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_cmd)
                  CMD_CLEAR: op = OP_CLEAR;
                  CMD_ADD: begin
                     if (!status.self_loop) begin
                        op = OP_EDGE_A;
                        state_in = ST_EDGE_WA;
                     end
                  end
                  CMD_SOLVE: state_in = ST_INIT;
                  default: ;
               endcase
            end
         end
         ST_EDGE_WA: begin
            op = OP_EDGE_WA;
            state_in = ST_EDGE_WB;
         end
         ST_EDGE_WB: begin
            op = OP_EDGE_WB;
            state_in = ST_IDLE;
         end
         ST_INIT: begin
            op = OP_INIT;
            state_in = ST_ENTER;
         end
         ST_ENTER: begin
            if (status.steps_out) begin
               op = OP_FIN_EXH;
               state_in = ST_DONE;
            end else begin
               op = OP_ENTER;
               state_in = ST_CLASS;
            end
         end
         ST_CLASS: begin
            if (status.p_zero) begin
               op = OP_CLASS_END;
               state_in = ST_BRANCH;
            end else if (status.steps_out) begin
               op = OP_FIN_EXH;
               state_in = ST_DONE;
            end else begin
               op = OP_CLASS;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (status.q_zero) begin
               op = OP_NEXT_COL;
               state_in = ST_CLASS;
            end else begin
               op = OP_PICK;
               state_in = ST_ADJ;
            end
         end
         ST_ADJ: begin
            op = OP_ADJ_MASK;
            state_in = ST_PICK;
         end
         ST_BRANCH: begin
            if (status.i_neg) begin
               if (status.d_zero) begin
                  state_in = ST_DONE;
               end else begin
                  op = OP_POP1;
                  state_in = ST_POP2;
               end
            end else begin
               op = OP_BR_ISSUE;
               state_in = ST_BR_E;
            end
         end
         ST_BR_E: begin
            if (status.prune) begin
               op = OP_PRUNE;
               state_in = ST_BRANCH;
            end else begin
               op = OP_BR_TAKE;
               state_in = ST_BR_ADJ;
            end
         end
         ST_BR_ADJ: begin
            if (status.leaf) begin
               op = OP_LEAF;
               state_in = ST_BRANCH;
            end else begin
               op = OP_DESCEND;
               state_in = ST_ENTER;
            end
         end
         ST_POP2: begin
            op = OP_POP2;
            state_in = ST_POP3;
         end
         ST_POP3: begin
            op = OP_POP3;
            state_in = ST_BRANCH;
         end
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               op = OP_LOAD_RSP;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (op == OP_LOAD_RSP) |-> !rsp_valid_ff) else $error("result overwritten");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("accept while busy");
   a_done_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (op == OP_LOAD_RSP) |=> rsp_valid_ff) else $error("result lost");

endmodule
`default_nettype wire

FILE: src/mcbb_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module mcbb_dpath
   import mcbb_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire op_type              op,
   input  wire logic [VW-1:0]       req_a,
   input  wire logic [VW-1:0]       req_b,
   input  wire logic                csr_we,
   input  wire logic                csr_index,
   input  wire logic [BUDGET_W-1:0] csr_wdata,
   output status_type               status,
   output logic [CW-1:0]            rsp_size,
   output logic [MAX_VERTICES-1:0]  rsp_mask,
   output logic                     rsp_exh
);

   localparam logic [MAX_VERTICES-1:0] ONE = MAX_VERTICES'(1);

   // config
   logic [CW-1:0] vc_ff;
   logic [BUDGET_W-1:0] budget_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= VC_RESET;
         budget_ff <= BUDGET_RESET;
      end else if (csr_we) begin
         if (csr_index == REG_VERTEX_COUNT) vc_ff <= csr_wdata[CW-1:0];
         else budget_ff <= csr_wdata;
      end
   end

   // adjacency store with per-row valid bits
   logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] row_ok_ff;
   logic [MAX_VERTICES-1:0] adj_rd_ff;
   logic rd_ok_ff;
   logic [VW-1:0] adj_raddr, adj_waddr;
   logic adj_we;
   logic [MAX_VERTICES-1:0] adj_wdata, adj_q;

   // search registers
   logic [VW-1:0] a_ff, a_in, b_ff, b_in, d_ff, d_in, v_ff, v_in;
   logic [MAX_VERTICES-1:0] p_ff, p_in, q_ff, q_in, cand_ff, cand_in;
   logic [MAX_VERTICES-1:0] clique_ff, clique_in, best_mask_ff, best_mask_in;
   logic [CW-1:0] size_ff, size_in, best_ff, best_in, k_ff, k_in, col_ff, col_in;
   logic [CW-1:0] i_ff, i_in;
   logic [STEPS_W-1:0] steps_ff, steps_in;
   logic exh_ff, exh_in;
   logic [CW-1:0] rsp_size_ff, rsp_size_in;
   logic [MAX_VERTICES-1:0] rsp_mask_ff, rsp_mask_in;
   logic rsp_exh_ff, rsp_exh_in;

   // stacks
   logic [MAX_VERTICES-1:0] cand_mem [MAX_VERTICES];
   logic [CW-1:0] cur_mem [MAX_VERTICES];
   logic [ENTRY_W-1:0] cos_mem [MAX_VERTICES * MAX_VERTICES];
   logic [MAX_VERTICES-1:0] cand_rd_ff;
   logic [CW-1:0] cur_rd_ff;
   logic [ENTRY_W-1:0] cos_rd_ff;
   logic [COS_AW-1:0] cos_raddr;
   logic [VW-1:0] pop_addr, low_v, e_v;
   logic [CW-1:0] e_col;
   logic [MAX_VERTICES-1:0] vmask, q_br;
   logic [CW:0] bound;

   assign adj_q = rd_ok_ff ? adj_rd_ff : '0;
   assign pop_addr = d_ff - VW'(1);
   assign e_v = cos_rd_ff[VW-1:0];
   assign e_col = cos_rd_ff[ENTRY_W-1:VW];
   assign bound = {1'b0, e_col} + {1'b0, size_ff};
   assign q_br = cand_ff & adj_q;

   // lowest set bit of q
   always_comb begin
      low_v = '0;
      for (int j = MAX_VERTICES - 1; j >= 0; j--) begin
         if (q_ff[j]) low_v = VW'(j);
      end
   end

   always_comb begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
         vmask[j] = (CW'(j) < vc_ff);
      end
   end

   always_comb begin
      case (op)
         OP_EDGE_A:  adj_raddr = req_a;
         OP_EDGE_WA: adj_raddr = b_ff;
         OP_PICK:    adj_raddr = low_v;
         default:    adj_raddr = e_v;
      endcase
      cos_raddr = (op == OP_POP2) ? {d_ff, cur_rd_ff[VW-1:0]} : {d_ff, i_ff[VW-1:0]};
      adj_we = (op == OP_EDGE_WA) || (op == OP_EDGE_WB);
      adj_waddr = (op == OP_EDGE_WA) ? a_ff : b_ff;
      adj_wdata = adj_q | ((op == OP_EDGE_WA) ? (ONE << b_ff) : (ONE << a_ff));
   end

   always_ff @(posedge clock) begin
      if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
      adj_rd_ff <= adj_mem[adj_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset || op == OP_CLEAR) begin
         row_ok_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (adj_we) row_ok_ff[adj_waddr] <= 1'b1;
         rd_ok_ff <= row_ok_ff[adj_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (op == OP_DESCEND) begin
         cand_mem[d_ff] <= cand_ff;
         cur_mem[d_ff] <= i_ff;
      end
      cand_rd_ff <= cand_mem[pop_addr];
      cur_rd_ff <= cur_mem[pop_addr];
   end

   always_ff @(posedge clock) begin
      if (op == OP_PICK) cos_mem[{d_ff, k_ff[VW-1:0]}] <= {col_ff, low_v};
      cos_rd_ff <= cos_mem[cos_raddr];
   end

   always_comb begin
      a_in = a_ff; b_in = b_ff; d_in = d_ff; v_in = v_ff;
      p_in = p_ff; q_in = q_ff; cand_in = cand_ff;
      clique_in = clique_ff; best_mask_in = best_mask_ff;
      size_in = size_ff; best_in = best_ff; k_in = k_ff; col_in = col_ff; i_in = i_ff;
      steps_in = steps_ff; exh_in = exh_ff;
      rsp_size_in = rsp_size_ff; rsp_mask_in = rsp_mask_ff; rsp_exh_in = rsp_exh_ff;
      case (op)
         OP_EDGE_A: begin
            a_in = req_a;
            b_in = req_b;
         end
         OP_INIT: begin
            steps_in = {1'b0, budget_ff};
            exh_in = 1'b0;
            best_in = '0;
            best_mask_in = '0;
            clique_in = '0;
            size_in = '0;
            d_in = '0;
            cand_in = vmask;
         end
         OP_ENTER: begin
            p_in = cand_ff;
            k_in = '0;
            col_in = CW'(1);
         end
         OP_CLASS: q_in = p_ff;
         OP_CLASS_END: i_in = k_ff - CW'(1);
         OP_PICK: begin
            if (steps_ff != STEPS_MIN) steps_in = steps_ff - STEPS_W'(1);
            p_in = p_ff & ~(ONE << low_v);
            q_in = q_ff & ~(ONE << low_v);
            k_in = k_ff + CW'(1);
         end
         OP_NEXT_COL: col_in = col_ff + CW'(1);
         OP_ADJ_MASK: q_in = q_ff & ~adj_q;
         OP_BR_ISSUE: begin
            if (steps_ff != STEPS_MIN) steps_in = steps_ff - STEPS_W'(1);
         end
         OP_PRUNE: i_in = '1;
         OP_BR_TAKE: begin
            v_in = e_v;
            clique_in = clique_ff | (ONE << e_v);
            size_in = size_ff + CW'(1);
         end
         OP_LEAF: begin
            if (size_ff > best_ff) begin
               best_in = size_ff;
               best_mask_in = clique_ff;
            end
            clique_in = clique_ff & ~(ONE << v_ff);
            size_in = size_ff - CW'(1);
            cand_in = cand_ff & ~(ONE << v_ff);
            i_in = i_ff - CW'(1);
         end
         OP_DESCEND: begin
            d_in = d_ff + VW'(1);
            cand_in = q_br;
         end
         OP_POP1: d_in = pop_addr;
         OP_POP2: begin
            cand_in = cand_rd_ff;
            i_in = cur_rd_ff;
         end
         OP_POP3: begin
            clique_in = clique_ff & ~(ONE << e_v);
            size_in = size_ff - CW'(1);
            cand_in = cand_ff & ~(ONE << e_v);
            i_in = i_ff - CW'(1);
         end
         OP_FIN_EXH: exh_in = 1'b1;
         OP_LOAD_RSP: begin
            rsp_size_in = best_ff;
            rsp_mask_in = best_mask_ff;
            rsp_exh_in = exh_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clique_ff <= '0;
         size_ff <= '0;
         best_ff <= '0;
         best_mask_ff <= '0;
         steps_ff <= '0;
         exh_ff <= 1'b0;
         i_ff <= '0;
      end else begin
         clique_ff <= clique_in;
         size_ff <= size_in;
         best_ff <= best_in;
         best_mask_ff <= best_mask_in;
         steps_ff <= steps_in;
         exh_ff <= exh_in;
         i_ff <= i_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; d_ff <= d_in; v_ff <= v_in;
      p_ff <= p_in; q_ff <= q_in; cand_ff <= cand_in;
      k_ff <= k_in; col_ff <= col_in;
      rsp_size_ff <= rsp_size_in; rsp_mask_ff <= rsp_mask_in; rsp_exh_ff <= rsp_exh_in;
   end

   always_comb begin
      status.self_loop = (req_a == req_b);
      status.p_zero = (p_ff == '0);
      status.q_zero = (q_ff == '0);
      status.steps_out = steps_ff[STEPS_W-1] || (steps_ff == '0);
      status.i_neg = i_ff[CW-1];
      status.d_zero = (d_ff == '0);
      status.prune = (bound <= {1'b0, best_ff});
      status.leaf = (q_br == '0) || (&d_ff);
   end

   assign rsp_size = rsp_size_ff;
   assign rsp_mask = rsp_mask_ff;
   assign rsp_exh = rsp_exh_ff;

   a_size_count: assert property (@(posedge clock) disable iff (reset)
      $countones(clique_ff) == 32'(size_ff)) else $error("clique size drift");
   a_best_count: assert property (@(posedge clock) disable iff (reset)
      $countones(best_mask_ff) == 32'(best_ff)) else $error("best size drift");
   a_leaf_cursor: assert property (@(posedge clock) disable iff (reset)
      (op == OP_LEAF) |-> !i_ff[CW-1]) else $error("leaf with empty cursor");

endmodule
`default_nettype wire

FILE: src/max_clique_bitset_branch_bound.sv
// Maximum clique search, bitset branch and bound over up to 64 vertices.
// Input stream (req_*): one beat per command. Add edge is a read-modify-write
// of both adjacency rows through one memory port. Solve takes a data-dependent
// time that grows with colored vertices, color classes, branches (pruned ones
// cheaper than descents) and backtracks, set by the single-ported stack and
// adjacency memories. Only solve returns a result beat on rsp_*.
// req_tready is high only while the controller is idle, so commands are
// taken one at a time; clear and add edge never produce a beat.
// Result is held in an output register; a stalled receiver does not block
// the next command, but a second solve waits at its end until the
// previous result is taken.
// The user writes config (csr_*) only while idle, not enforced. Index 0 vertex_count,
// 1 step_budget. Reset (synchronous) empties the graph via row valid bits, restores
// the config defaults and drops any pending result. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module max_clique_bitset_branch_bound
   import mcbb_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [15:0]         req_tdata,   // cmd[1:0], vertex_a[7:2], vertex_b[13:8]
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [71:0]              rsp_tdata,   // clique_size[6:0], member_mask[70:7]
   output logic                     rsp_tuser,   // budget_exhausted
   input  wire logic                csr_we,
   input  wire logic                csr_index,
   input  wire logic [BUDGET_W-1:0] csr_wdata
);

   op_type op;
   status_type status;
   logic [CW-1:0] rsp_size;
   logic [MAX_VERTICES-1:0] rsp_mask;
   logic rsp_exh;

   mcbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_cmd   (req_tdata[1:0]),
      .rsp_ready (rsp_tready),
      .status    (status),
      .op        (op),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid)
   );

   mcbb_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .req_a     (req_tdata[7:2]),
      .req_b     (req_tdata[13:8]),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_size  (rsp_size),
      .rsp_mask  (rsp_mask),
      .rsp_exh   (rsp_exh)
   );

   assign rsp_tdata = {1'b0, rsp_mask, rsp_size};
   assign rsp_tuser = rsp_exh;

endmodule
`default_nettype wire

FILE: sim/tb_max_clique_bitset_branch_bound.sv
`timescale 1ns / 1ps
module tb_max_clique_bitset_branch_bound;
   import mcbb_pkg::*;

   localparam int CYCLE_LIMIT = 6000000;
   localparam int LONG_STALL  = 3000;
   localparam logic [1:0] CMD_BOGUS = 2'd3;   // not a defined command, dropped by the block

   typedef struct {
      logic [6:0]  size;
      logic [63:0] mask;
      logic        exhausted;
   } clique_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata = '0;   // cmd[1:0], vertex_a[7:2], vertex_b[13:8]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [71:0]         rsp_tdata;        // clique_size[6:0], member_mask[70:7]
   logic                rsp_tuser;        // budget_exhausted
   logic                csr_we = 1'b0;
   logic                csr_index = REG_VERTEX_COUNT;
   logic [BUDGET_W-1:0] csr_wdata = '0;

   max_clique_bitset_branch_bound i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Clique search predictor: own copy of graph, config and search stacks
   // ---------------------------------------------------------------------
   logic [6:0]    vc_shadow = 7'd64;
   logic [36:0]   budget_shadow = BUDGET_RESET;
   logic [63:0]   graph_rows [64];
   logic [63:0]   cand_sets [64];
   logic [12:0]   color_order [4096];   // color << 6 | vertex
   int            order_cursor [64];
   longint        steps_remaining;
   bit            search_halted;
   logic [63:0]   clique_now, clique_best;
   int            best_count;

   clique_result_type cliques_due[$];
   logic [15:0]       cmd_fifo[$];

   initial foreach (graph_rows[i]) graph_rows[i] = '0;

   function automatic int low_index(logic [63:0] x);
      int i;
      i = 0;
      while (i < 63 && !x[i]) i++;
      return i;
   endfunction

   // Budget check, greedy coloring of level d, cursor at the last vertex colored.
   function automatic void color_level(int d);
      logic [63:0] pool, cls;
      int k, col, v;
      pool = cand_sets[d];
      k = 0;
      col = 1;
      if (steps_remaining <= 0) begin
         search_halted = 1'b1;
         return;
      end
      while (pool != 0) begin
         if (steps_remaining <= 0) begin
            search_halted = 1'b1;
            return;
         end
         cls = pool;
         while (cls != 0) begin
            v = low_index(cls);
            steps_remaining--;
            pool[v] = 1'b0;
            cls[v] = 1'b0;
            cls &= ~graph_rows[v];
            if (k < 64) color_order[d*64 + k] = {col[6:0], v[5:0]};
            k++;
         end
         col++;
      end
      order_cursor[d] = k - 1;
   endfunction

   function automatic clique_result_type search_clique();
      clique_result_type r;
      int n, d, i, v, col;
      logic [12:0] e;
      logic [63:0] nbr;
      n = (vc_shadow > 64) ? 64 : int'(vc_shadow);
      steps_remaining = longint'(budget_shadow);
      search_halted = 1'b0;
      best_count = 0;
      clique_best = '0;
      clique_now = '0;
      cand_sets[0] = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      d = 0;
      color_level(0);
      while (!search_halted) begin
         i = order_cursor[d];
         if (i < 0) begin
            if (d == 0) break;
            d--;
            e = color_order[d*64 + order_cursor[d]];
            clique_now[e[5:0]] = 1'b0;
            cand_sets[d][e[5:0]] = 1'b0;
            order_cursor[d]--;
            continue;
         end
         steps_remaining--;
         e = color_order[d*64 + i];
         v = e[5:0];
         col = e[12:6];
         if (col + $countones(clique_now) <= best_count) begin
            order_cursor[d] = -1;   // bound: nothing left here can beat the best
            continue;
         end
         clique_now[v] = 1'b1;
         nbr = cand_sets[d] & graph_rows[v];
         if (nbr == 0 || d + 1 >= 64) begin
            if ($countones(clique_now) > best_count) begin
               best_count = $countones(clique_now);
               clique_best = clique_now;
            end
            clique_now[v] = 1'b0;
            cand_sets[d][v] = 1'b0;
            order_cursor[d]--;
         end else begin
            d++;
            cand_sets[d] = nbr;
            color_level(d);
         end
      end
      r.size = best_count[6:0];
      r.mask = clique_best;
      r.exhausted = search_halted;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus knobs shared with the clocked processes
   // ---------------------------------------------------------------------
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int stall_requests = 0;
   int stall_served = 0;
   int stall_left = 0;
   bit req_took = 1'b0;
   int mismatches = 0;
   int cycle_count = 0;

   // Driver: new beat offered at the falling edge once the last one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (cmd_fifo.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
            req_tdata  <= cmd_fifo.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver backpressure, with an occasional long hold-off on request.
   always @(negedge clock) begin
      if (stall_requests != stall_served) begin
         stall_served = stall_requests;
         stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Monitor: accepted commands feed the predictor, result beats are checked.
   always @(posedge clock) begin
      clique_result_type want;
      logic [1:0] op;
      logic [5:0] va, vb;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         req_took <= req_tvalid && req_tready && !reset;
         if (!reset && req_tvalid && req_tready) begin
            op = req_tdata[1:0];
            va = req_tdata[7:2];
            vb = req_tdata[13:8];
            case (op)
               CMD_CLEAR: foreach (graph_rows[i]) graph_rows[i] = '0;
               CMD_ADD: if (va != vb) begin
                  graph_rows[va][vb] = 1'b1;
                  graph_rows[vb][va] = 1'b1;
               end
               CMD_SOLVE: cliques_due.push_back(search_clique());
               default: ;
            endcase
         end
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (cliques_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: size %0d mask %h exh %b",
                           rsp_tdata[6:0], rsp_tdata[70:7], rsp_tuser);
            end else begin
               want = cliques_due.pop_front();
               if (rsp_tdata[6:0] !== want.size || rsp_tdata[70:7] !== want.mask
                   || rsp_tuser !== want.exhausted) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("clique mismatch: exp size %0d mask %h exh %b, got %0d %h %b",
                              want.size, want.mask, want.exhausted,
                              rsp_tdata[6:0], rsp_tdata[70:7], rsp_tuser);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer helpers
   // ---------------------------------------------------------------------
   int queued = 0;

   task automatic push_cmd(logic [1:0] op, logic [5:0] va, logic [5:0] vb);
      cmd_fifo.push_back({2'b00, vb, va, op});
      queued++;
   endtask

   // Sender holds back until all beats went out and every result came home.
   task automatic drain_all();
      wait (cmd_fifo.size() == 0 && !req_tvalid && cliques_due.size() == 0);
      repeat (16) @(posedge clock);   // an add edge may still be writing rows
      wait (req_tready);
   endtask

   task automatic write_csr(logic idx, logic [BUDGET_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == REG_VERTEX_COUNT) vc_shadow = val[6:0];
      else budget_shadow = val[36:0];
   endtask

   task automatic set_config(logic [6:0] vc, logic [36:0] budget);
      drain_all();
      write_csr(REG_VERTEX_COUNT, BUDGET_W'(vc));
      write_csr(REG_STEP_BUDGET, budget);
   endtask

   // Clear, plant a clique, sprinkle random edges plus some noise, solve.
   task automatic graph_and_solve(int span, int n_edges);
      int k;
      logic [5:0] pick [8];
      push_cmd(CMD_CLEAR, 6'($urandom), 6'($urandom));
      k = $urandom_range(0, (span < 7) ? span : 7);
      for (int i = 0; i < k; i++) pick[i] = 6'($urandom_range(span - 1));
      for (int i = 0; i < k; i++)
         for (int j = i + 1; j < k; j++) push_cmd(CMD_ADD, pick[i], pick[j]);
      for (int i = 0; i < n_edges; i++) begin
         case ($urandom_range(99)) inside
            [0:4]:   push_cmd(CMD_ADD, 6'($urandom), 6'($urandom));   // anywhere, also unused
            [5:7]:   begin k = $urandom_range(63); push_cmd(CMD_ADD, 6'(k), 6'(k)); end
            [8:10]:  push_cmd(CMD_BOGUS, 6'($urandom), 6'($urandom));
            default: push_cmd(CMD_ADD, 6'($urandom_range(span - 1)),
                              6'($urandom_range(span - 1)));
         endcase
      end
      push_cmd(CMD_SOLVE, 6'($urandom), 6'($urandom));
   endtask

   initial begin
      int span;
      logic [6:0] vc;
      logic [36:0] budget;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset config (64 vertices, huge budget), empty graph first.
      tx_idle_pct = 35;
      rx_idle_pct = 86;
      push_cmd(CMD_SOLVE, 6'd0, 6'd0);
      push_cmd(CMD_ADD, 6'd63, 6'd62);
      push_cmd(CMD_ADD, 6'd0, 6'd63);
      push_cmd(CMD_ADD, 6'd0, 6'd62);      // triangle 0, 62, 63
      push_cmd(CMD_ADD, 6'd5, 6'd5);       // self loop, dropped
      push_cmd(CMD_BOGUS, 6'd1, 6'd2);     // unknown command, dropped
      push_cmd(CMD_SOLVE, 6'd63, 6'd63);
      push_cmd(CMD_CLEAR, 6'd63, 6'd0);
      push_cmd(CMD_SOLVE, 6'd0, 6'd0);     // cleared graph: single vertex
      drain_all();

      // No vertices, zero budget, then no vertices with a budget.
      set_config(7'd0, 37'd0);
      push_cmd(CMD_ADD, 6'd1, 6'd2);
      push_cmd(CMD_SOLVE, 6'd0, 6'd0);
      set_config(7'd0, 37'd5);
      push_cmd(CMD_SOLVE, 6'd0, 6'd0);
      // Count above the maximum with the largest budget, edges to 63.
      set_config(7'd127, '1);
      push_cmd(CMD_ADD, 6'd63, 6'd1);
      push_cmd(CMD_ADD, 6'd1, 6'd2);
      push_cmd(CMD_ADD, 6'd2, 6'd63);
      push_cmd(CMD_SOLVE, 6'd0, 6'd0);
      // One vertex, minimal budget; then edge to an unused vertex.
      set_config(7'd1, 37'd1);
      push_cmd(CMD_SOLVE, 6'd0, 6'd0);
      set_config(7'd2, 37'd3);
      push_cmd(CMD_ADD, 6'd0, 6'd1);
      push_cmd(CMD_ADD, 6'd1, 6'd40);
      push_cmd(CMD_SOLVE, 6'd0, 6'd0);

      // Long receiver hold-off with solves queued behind it: input must stall.
      set_config(7'd16, 37'd200);
      stall_requests++;
      for (int i = 0; i < 3; i++) graph_and_solve(16, 10);
      drain_all();

      // Random part: three idling regimes by progress.
      while (queued < 1050) begin
         if (queued > 700) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end else if (queued > 350) begin
            tx_idle_pct = 86;
            rx_idle_pct = 35;
         end
         case ($urandom_range(9))
            0, 1:    vc = 7'($urandom_range(1, 64));
            2:       vc = 7'($urandom_range(65, 127));
            default: vc = 7'($urandom_range(1, 14));
         endcase
         span = (vc > 64) ? 64 : int'(vc);
         if (span <= 14 && $urandom_range(2) == 0) budget = '1;
         else if ($urandom_range(4) == 0) budget = 37'($urandom_range(0, 40));
         else budget = 37'($urandom_range(1, 2500));
         set_config(vc, budget);
         for (int g = $urandom_range(1, 3); g > 0; g--)
            graph_and_solve((span < 64 && $urandom_range(4) == 0) ? span + 1 : span,
                            $urandom_range(3, 4 * span + 4));
      end

      drain_all();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && cliques_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
